// ===== hw/rtl/hs_pkg.sv =====
// Shared types and constants for the heap sorter.
`timescale 1ns / 1ps
package hs_pkg;

  // Width of one sorted value.
  localparam int DATA_W = 32;

  // One stored value, compared as a signed number.
  typedef logic signed [DATA_W-1:0] word_t;

endpackage

// ===== hw/rtl/hs_store.sv =====
// Element store of the heap sorter: one write port, one registered read port.
`timescale 1ns / 1ps
module hs_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  hs_pkg::word_t      wr_data,
  input  logic [AW-1:0]      rd_addr,
  output hs_pkg::word_t      rd_data
);

  hs_pkg::word_t mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; a read of the address being written returns the old value.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hw/rtl/heap_sorter_top.sv =====
// Top level of the heap sorter: stream ports, sort sequencer and shared comparator.
// Loading accepts one value per cycle; the last value of a batch starts the sort.
// Sorting builds a heap over the n loaded values, then makes n - 1 root moves; each sift
// level uses the single read port of the store and the one shared signed comparator.
// Each result then passes through S_EMIT and S_EMITW and is held in S_OUTH until taken;
// s_tready is low until the last result of the batch is taken. Reset clears the counters,
// the sequencer and m_tvalid only; store contents stay undefined and need no clearing pass.
`timescale 1ns / 1ps
module heap_sorter_top #(
  parameter int MAX_ITEMS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic        s_tlast,   // last_item
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] sorted_value
  output logic        m_tlast,   // last_result
  output logic [0:0]  m_tuser    // [0] overflowed
);

  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int IW = AW + 2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BUILD,
    S_FETCH,
    S_RD_L,
    S_RD_R,
    S_CMPR,
    S_CMPV,
    S_SORT,
    S_SWPA,
    S_SWPB,
    S_EMIT,
    S_EMITW,
    S_OUTH
  } state_t;

  state_t           state;
  logic [CW-1:0]    cnt;
  logic             ovf;
  logic [CW-1:0]    hsize;
  logic [CW-1:0]    bidx;
  logic             sorting;
  logic [AW-1:0]    node;
  logic [AW-1:0]    child;
  logic [AW-1:0]    k;
  hs_pkg::word_t    v;
  hs_pkg::word_t    lval;
  hs_pkg::word_t    bval;

  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  hs_pkg::word_t    wr_data;
  logic [AW-1:0]    rd_addr;
  hs_pkg::word_t    rd_data;

  logic             cnt_full;
  logic [CW-1:0]    cnt_next;
  logic [IW-1:0]    l_idx;
  logic [IW-1:0]    r_idx;
  logic [IW-1:0]    hsize_ext;
  logic [CW-1:0]    hsize_dec;
  logic             in_acc;
  hs_pkg::word_t    cmp_a;
  hs_pkg::word_t    cmp_b;
  logic             gt;

  hs_store #(
    .DEPTH (MAX_ITEMS),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Index arithmetic for the current heap node.
  assign cnt_full  = (cnt == CW'(MAX_ITEMS));
  assign cnt_next  = cnt_full ? cnt : cnt + 1'b1;
  assign l_idx     = {1'b0, node, 1'b1};
  assign r_idx     = l_idx + 1'b1;
  assign hsize_ext = IW'(hsize);
  assign hsize_dec = hsize - 1'b1;
  assign in_acc    = s_tvalid && s_tready;
  assign s_tready  = (state == S_IDLE);

  // The one shared comparator: right child against left child, then winner against value.
  always_comb begin
    if (state == S_CMPR) begin
      cmp_a = rd_data;
      cmp_b = lval;
    end else begin
      cmp_a = bval;
      cmp_b = v;
    end
  end
  assign gt = (cmp_a > cmp_b);

  // Store port control by state.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = node;
    wr_data = v;
    rd_addr = node;
    case (state)
      S_IDLE: begin
        wr_en   = in_acc && !cnt_full;
        wr_addr = cnt[AW-1:0];
        wr_data = hs_pkg::word_t'(s_tdata);
      end
      S_BUILD: begin
        rd_addr = AW'(bidx - 1'b1);
      end
      S_RD_L: begin
        wr_en   = (l_idx >= hsize_ext);
        rd_addr = l_idx[AW-1:0];
      end
      S_RD_R: begin
        rd_addr = r_idx[AW-1:0];
      end
      S_CMPV: begin
        wr_en   = 1'b1;
        wr_data = gt ? bval : v;
      end
      S_SORT: begin
        rd_addr = '0;
      end
      S_SWPA: begin
        wr_en   = 1'b1;
        wr_addr = hsize_dec[AW-1:0];
        wr_data = rd_data;
        rd_addr = hsize_dec[AW-1:0];
      end
      S_EMIT: begin
        rd_addr = k;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Sequencer, counters and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      ovf      <= 1'b0;
      hsize    <= '0;
      bidx     <= '0;
      sorting  <= 1'b0;
      node     <= '0;
      child    <= '0;
      k        <= '0;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            cnt <= cnt_next;
            if (cnt_full) begin
              ovf <= 1'b1;
            end
            if (s_tlast) begin
              hsize   <= cnt_next;
              bidx    <= cnt_next >> 1;
              sorting <= 1'b0;
              state   <= S_BUILD;
            end
          end
        end
        // Heap build: sift down each inner node, last one first.
        S_BUILD: begin
          if (bidx == '0) begin
            sorting <= 1'b1;
            state   <= S_SORT;
          end else begin
            node  <= AW'(bidx - 1'b1);
            bidx  <= bidx - 1'b1;
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          v     <= rd_data;
          state <= S_RD_L;
        end
        // One sift level: fetch both children, pick the larger, compare with the value.
        S_RD_L: begin
          if (l_idx >= hsize_ext) begin
            state <= sorting ? S_SORT : S_BUILD;
          end else begin
            state <= S_RD_R;
          end
        end
        S_RD_R: begin
          lval  <= rd_data;
          state <= S_CMPR;
        end
        S_CMPR: begin
          if ((r_idx < hsize_ext) && gt) begin
            bval  <= rd_data;
            child <= r_idx[AW-1:0];
          end else begin
            bval  <= lval;
            child <= l_idx[AW-1:0];
          end
          state <= S_CMPV;
        end
        S_CMPV: begin
          if (gt) begin
            node  <= child;
            state <= S_RD_L;
          end else begin
            state <= sorting ? S_SORT : S_BUILD;
          end
        end
        // Move the root to the end of the heap and sift the displaced value from the top.
        S_SORT: begin
          if (hsize <= CW'(1)) begin
            k     <= '0;
            state <= S_EMIT;
          end else begin
            state <= S_SWPA;
          end
        end
        S_SWPA: begin
          state <= S_SWPB;
        end
        S_SWPB: begin
          v     <= rd_data;
          hsize <= hsize_dec;
          node  <= '0;
          state <= S_RD_L;
        end
        // Emit the store in address order.
        S_EMIT: begin
          state <= S_EMITW;
        end
        S_EMITW: begin
          m_tdata    <= rd_data;
          m_tlast    <= (CW'(k) == cnt - 1'b1);
          m_tuser[0] <= ovf;
          m_tvalid   <= 1'b1;
          state      <= S_OUTH;
        end
        S_OUTH: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            if (m_tlast) begin
              cnt   <= '0;
              ovf   <= 1'b0;
              state <= S_IDLE;
            end else begin
              k     <= k + 1'b1;
              state <= S_EMIT;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Input and output sides are never open together.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input ready while a result is pending");

  // The fill count never passes capacity.
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(MAX_ITEMS))
    else $error("item count beyond capacity");

  // The heap never grows past the loaded batch.
  a_heap_bound: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (hsize <= cnt))
    else $error("heap size larger than batch");

  // Taking the final result reopens the input with an empty batch.
  a_batch_close: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> (s_tready && cnt == '0 && !ovf))
    else $error("batch not closed after final result");

endmodule
